// ===== design/gper_pkg.sv =====
// ---------------------------------------------------------------------------
// gper_pkg: shared types and constants
// Register indexes, reset values, field widths and the per-port result
// bundle used by the gamepad edge and key repeat core.
// ---------------------------------------------------------------------------
package gper_pkg;

  localparam int unsigned NUM_BUTTONS = 14;
  localparam int unsigned RAW_W       = 16;
  localparam int unsigned STICK_W     = 8;
  localparam int unsigned CNT_W       = 8;
  localparam int unsigned DIR_W       = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned IN_DATA_W   = 72;
  localparam int unsigned OUT_DATA_W  = 96;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LAYOUT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PORT_ENABLE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD      = 2'd3;

  // register reset values
  localparam logic       LAYOUT_RST      = 1'b0;
  localparam logic [1:0] PORT_ENABLE_RST = 2'd3;
  localparam logic [CNT_W-1:0] DELAY_RST  = 8'd24;
  localparam logic [CNT_W-1:0] PERIOD_RST = 8'd5;

  localparam logic [STICK_W-1:0] STICK_BIAS = 8'h80;

  typedef logic [NUM_BUTTONS-1:0] btn_mask_t;

  // what one pad port contributes to a frame
  typedef struct packed {
    logic                 link;      // enabled and pad ready
    logic                 counted;   // link and read succeeded
    logic                 stick_ok;  // counted and analog mode
    logic [RAW_W-1:0]     raw;       // inverted buttons, 0 if not counted
    btn_mask_t            logical;
    logic [STICK_W-1:0]   stick_x;
    logic [STICK_W-1:0]   stick_y;
  } port_res_t;

endpackage

// ===== design/gper_port.sv =====
// ---------------------------------------------------------------------------
// gper_port: one pad port
// Qualifies the port reading, inverts the active-low button word, maps it
// onto the logical buttons and removes the stick bias.
// ---------------------------------------------------------------------------
module gper_port (
  input  logic                    enable,
  input  logic                    layout,
  input  logic                    ready,
  input  logic                    read_ok,
  input  logic [15:0]             buttons,
  input  logic                    analog,
  input  logic [7:0]              stick_h,
  input  logic [7:0]              stick_v,
  output gper_pkg::port_res_t     res
);
  import gper_pkg::*;

  logic [RAW_W-1:0] raw;
  btn_mask_t        lmap;

  assign raw = ~buttons;

  always_comb begin
    lmap     = '0;
    lmap[0]  = raw[4];   // up
    lmap[1]  = raw[6];   // down
    lmap[2]  = raw[7];   // left
    lmap[3]  = raw[5];   // right
    // swap confirm and back by layout
    lmap[4]  = layout ? raw[13] : raw[14];
    lmap[5]  = layout ? raw[14] : raw[13];
    lmap[6]  = raw[12];
    lmap[7]  = raw[15];
    lmap[8]  = raw[10];
    lmap[9]  = raw[11];
    lmap[10] = raw[8];
    lmap[11] = raw[9];
    lmap[12] = raw[3];
    lmap[13] = raw[0];
  end

  always_comb begin
    res          = '0;
    res.link     = enable & ready;
    res.counted  = enable & ready & read_ok;
    res.stick_ok = enable & ready & read_ok & analog;
    res.raw      = res.counted ? raw : '0;
    res.logical  = res.counted ? lmap : '0;
    res.stick_x  = stick_h ^ STICK_BIAS;
    res.stick_y  = stick_v ^ STICK_BIAS;
  end

endmodule

// ===== design/gamepad_edge_and_key_repeat_core.sv =====
// ---------------------------------------------------------------------------
// gamepad_edge_and_key_repeat_core: pad edge detection and direction repeat
// Merges two pad ports per frame beat, gives held, pressed, released and
// auto-repeated logical buttons, port 0 raw buttons and the stick.
// ---------------------------------------------------------------------------
//  channel   | signals                        | content
//  ----------+--------------------------------+-----------------------------
//  frame in  | s_tvalid s_tready s_tdata[71:0] | two port readings per beat
//  result    | m_tvalid m_tready m_tdata[95:0] | one result beat per frame
//  config    | cfg_wen cfg_addr cfg_wdata      | layout, enable, delay, period
//
//  One frame beat per clock while s_tready is high; each result is registered
//  in the single output register, or in the skid register while it is held.
//  A skid register holds one more result while m_tready is low; s_tready
//  drops only when both are full.
//  rst (synchronous) clears history and repeat counters and loads register
//  defaults: layout 0, both ports enabled, delay 24, period 5.
// ---------------------------------------------------------------------------
module gamepad_edge_and_key_repeat_core (
  input  logic                              clk,
  input  logic                              rst,
  // p0_ready, p0_read_ok, p0_buttons[15:0], p0_analog, p0_stick_h[7:0],
  // p0_stick_v[7:0], p1_ready, p1_read_ok, p1_buttons[15:0], p1_analog,
  // p1_stick_h[7:0], p1_stick_v[7:0], zero fill
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [gper_pkg::IN_DATA_W-1:0]    s_tdata,
  // held[13:0], pressed[13:0], released[13:0], repeated[13:0],
  // raw_buttons[15:0], stick_x[7:0], stick_y[7:0], connected, zero fill
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [gper_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                              cfg_wen,
  input  logic [gper_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [gper_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import gper_pkg::*;

  // configuration
  logic             layout;
  logic [1:0]       port_enable;
  logic [CNT_W-1:0] repeat_delay;
  logic [CNT_W-1:0] repeat_period;

  // frame history
  btn_mask_t        prev_held;
  logic [DIR_W-1:0] repeat_dirs;
  logic [CNT_W-1:0] hold_count;
  logic [CNT_W-1:0] repeat_phase;

  btn_mask_t        prev_held_next;
  logic [DIR_W-1:0] repeat_dirs_next;
  logic [CNT_W-1:0] hold_count_next;
  logic [CNT_W-1:0] repeat_phase_next;

  // output register and skid
  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  logic                  skid_valid;
  logic [OUT_DATA_W-1:0] skid_data;

  port_res_t        p0_res;
  port_res_t        p1_res;
  logic             accept;
  btn_mask_t        held;
  btn_mask_t        pressed;
  btn_mask_t        released;
  btn_mask_t        repeated;
  logic [DIR_W-1:0] dirs;
  logic [DIR_W-1:0] pulse;
  logic [CNT_W-1:0] hold_inc;
  logic [CNT_W-1:0] phase_inc;
  logic [STICK_W-1:0] stick_x;
  logic [STICK_W-1:0] stick_y;
  logic             connected;
  logic [OUT_DATA_W-1:0] result;

  assign s_tready = ~skid_valid;
  assign accept   = s_tvalid & s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  gper_port u_port0 (
    .enable  (port_enable[0]),
    .layout  (layout),
    .ready   (s_tdata[0]),
    .read_ok (s_tdata[1]),
    .buttons (s_tdata[17:2]),
    .analog  (s_tdata[18]),
    .stick_h (s_tdata[26:19]),
    .stick_v (s_tdata[34:27]),
    .res     (p0_res)
  );

  gper_port u_port1 (
    .enable  (port_enable[1]),
    .layout  (layout),
    .ready   (s_tdata[35]),
    .read_ok (s_tdata[36]),
    .buttons (s_tdata[52:37]),
    .analog  (s_tdata[53]),
    .stick_h (s_tdata[61:54]),
    .stick_v (s_tdata[69:62]),
    .res     (p1_res)
  );

  assign held      = p0_res.logical | p1_res.logical;
  assign pressed   = held & ~prev_held;
  assign released  = ~held & prev_held;
  assign dirs      = held[DIR_W-1:0];
  assign connected = p0_res.link | p1_res.link;
  assign hold_inc  = hold_count + 8'd1;
  assign phase_inc = repeat_phase + 8'd1;

  // port 1 wins the stick
  always_comb begin
    if (p1_res.stick_ok) begin
      stick_x = p1_res.stick_x;
      stick_y = p1_res.stick_y;
    end else if (p0_res.stick_ok) begin
      stick_x = p0_res.stick_x;
      stick_y = p0_res.stick_y;
    end else begin
      stick_x = '0;
      stick_y = '0;
    end
  end

  // direction repeat timing
  always_comb begin
    prev_held_next    = held;
    repeat_dirs_next  = repeat_dirs;
    hold_count_next   = hold_count;
    repeat_phase_next = repeat_phase;
    pulse             = '0;
    if (dirs != repeat_dirs) begin
      // new direction set: restart timing, no pulse this frame
      repeat_dirs_next  = dirs;
      hold_count_next   = '0;
      repeat_phase_next = '0;
    end else if (dirs != '0) begin
      if (hold_count < repeat_delay) begin
        hold_count_next = hold_inc;
        if (hold_inc == repeat_delay) begin
          repeat_phase_next = '0;
          pulse             = dirs;
        end
      end else if (phase_inc >= repeat_period) begin
        repeat_phase_next = '0;
        pulse             = dirs;
      end else begin
        repeat_phase_next = phase_inc;
      end
    end
  end

  assign repeated = pressed | {{(NUM_BUTTONS-DIR_W){1'b0}}, pulse};

  assign result = {7'd0, connected, stick_y, stick_x, p0_res.raw,
                   repeated, released, pressed, held};

  always_ff @(posedge clk) begin
    if (rst) begin
      layout        <= LAYOUT_RST;
      port_enable   <= PORT_ENABLE_RST;
      repeat_delay  <= DELAY_RST;
      repeat_period <= PERIOD_RST;
    end else if (cfg_wen) begin
      case (cfg_addr)
        REG_LAYOUT:      layout        <= cfg_wdata[0];
        REG_PORT_ENABLE: port_enable   <= cfg_wdata[1:0];
        REG_DELAY:       repeat_delay  <= cfg_wdata;
        REG_PERIOD:      repeat_period <= cfg_wdata;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_held    <= '0;
      repeat_dirs  <= '0;
      hold_count   <= '0;
      repeat_phase <= '0;
    end else if (accept) begin
      prev_held    <= prev_held_next;
      repeat_dirs  <= repeat_dirs_next;
      hold_count   <= hold_count_next;
      repeat_phase <= repeat_phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      // output free this cycle: drain skid first, else take the new beat
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_data <= skid_valid ? skid_data : result;
    end else if (accept) begin
      skid_data <= result;
    end
  end

  a_press_release_apart: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[27:14] & m_tdata[41:28]) == '0))
    else $error("pressed and released overlap");

  a_pressed_in_repeated: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[27:14] & ~m_tdata[55:42]) == '0))
    else $error("pressed button missing from repeated");

  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output register");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    accept |=> m_tvalid)
    else $error("accepted frame produced no result");

  a_count_needs_dirs: assert property (@(posedge clk) disable iff (rst)
    (hold_count != '0) |-> (repeat_dirs != '0))
    else $error("hold count running with no direction held");

endmodule

// ===== verif/gamepad_edge_and_key_repeat_core_test.sv =====
// ---------------------------------------------------------------------------
// gamepad_edge_and_key_repeat_core_test: frame-by-frame check of the pad core
// Streams two-port pad frames into the core and predicts every result beat:
// held, pressed, released and auto-repeated buttons, port 0 raw buttons,
// stick bytes and the connected flag. The run steps through layouts, port
// enables and repeat timings, with random idling on both sides.
// ---------------------------------------------------------------------------
module gamepad_edge_and_key_repeat_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gper_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int SQUEEZE_CYCLES = 80;

  typedef struct packed {
    logic [7:0]  stick_v;
    logic [7:0]  stick_h;
    logic        analog;
    logic [15:0] buttons;
    logic        read_ok;
    logic        ready;
  } pad_read_t;

  typedef struct packed {
    logic [1:0] fill;
    pad_read_t  p1;
    pad_read_t  p0;
  } frame_t;

  typedef struct packed {
    logic [6:0]  fill;
    logic        connected;
    logic [7:0]  stick_y;
    logic [7:0]  stick_x;
    logic [15:0] raw_buttons;
    btn_mask_t   repeated;
    btn_mask_t   released;
    btn_mask_t   pressed;
    btn_mask_t   held;
  } frame_report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  gamepad_edge_and_key_repeat_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // register copies
  logic       layout_sel = LAYOUT_RST;
  logic [1:0] port_en = PORT_ENABLE_RST;
  logic [7:0] first_repeat_delay = DELAY_RST;
  logic [7:0] repeat_every = PERIOD_RST;

  // history copies
  btn_mask_t  last_held = '0;
  logic [3:0] timed_dirs = '0;
  logic [7:0] dir_hold_frames = '0;
  logic [7:0] repeat_phase_frames = '0;

  frame_t        frames_to_send[$];
  frame_report_t expected_reports[$];

  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   squeeze_req = 0;
  int   squeeze_seen = 0;
  int   squeeze_left = 0;
  int   mismatches = 0;
  int   reports_seen = 0;
  int   quiet_cycles = 0;
  logic in_taken = 1'b0;
  logic [3:0] carry_dirs = '0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic frame_report_t pad_frame_report(input frame_t f);
    frame_report_t r;
    pad_read_t     pads[2];
    logic [15:0]   down;
    btn_mask_t     held, rep;
    logic [3:0]    dirs;
    int            p;
    r = '0;
    held = '0;
    pads[0] = f.p0;
    pads[1] = f.p1;
    for (p = 0; p < 2; p++) begin
      if (port_en[p] && pads[p].ready) begin
        r.connected = 1'b1;
        if (pads[p].read_ok) begin
          down = ~pads[p].buttons;
          if (p == 0) r.raw_buttons = down;
          // later port overwrites the stick
          if (pads[p].analog) begin
            r.stick_x = pads[p].stick_h ^ STICK_BIAS;
            r.stick_y = pads[p].stick_v ^ STICK_BIAS;
          end
          held |= {down[0], down[3], down[9], down[8], down[11], down[10], down[15],
                   down[12], layout_sel ? down[14] : down[13],
                   layout_sel ? down[13] : down[14],
                   down[5], down[7], down[6], down[4]};
        end
      end
    end
    r.held = held;
    r.pressed = held & ~last_held;
    r.released = ~held & last_held;
    last_held = held;
    rep = r.pressed;
    dirs = held[3:0];
    if (dirs != timed_dirs) begin
      timed_dirs = dirs;
      dir_hold_frames = '0;
      repeat_phase_frames = '0;
    end else if (dirs != 4'd0) begin
      if (dir_hold_frames < first_repeat_delay) begin
        dir_hold_frames = dir_hold_frames + 8'd1;
        if (dir_hold_frames == first_repeat_delay) begin
          repeat_phase_frames = '0;
          rep[3:0] = rep[3:0] | dirs;
        end
      end else begin
        repeat_phase_frames = repeat_phase_frames + 8'd1;
        if (repeat_phase_frames >= repeat_every) begin
          repeat_phase_frames = '0;
          rep[3:0] = rep[3:0] | dirs;
        end
      end
    end
    r.repeated = rep;
    return r;
  endfunction

  function automatic pad_read_t reading(input logic rdy, input logic ok,
                                        input logic [15:0] btn, input logic an,
                                        input logic [7:0] h, input logic [7:0] v);
    return '{stick_v: v, stick_h: h, analog: an, buttons: btn, read_ok: ok, ready: rdy};
  endfunction

  function automatic pad_read_t noise_pad();
    return reading(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   16'($urandom_range(0, 16'hFFFF)), 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
  endfunction

  // one port carries the direction set, the rest is sparse random buttons
  function automatic frame_t steady_frame(input logic [3:0] dirs);
    pad_read_t   pr[2];
    logic [15:0] extra;
    int          carrier;
    int          p;
    carrier = (port_en == 2'b10) ? 1 : (port_en == 2'b01) ? 0 : int'($urandom_range(0, 1));
    for (p = 0; p < 2; p++) begin
      pr[p] = noise_pad();
      extra = 16'($urandom & $urandom & $urandom) & ~16'h00F0;
      if (p == carrier) begin
        extra[4] = dirs[0];
        extra[6] = dirs[1];
        extra[7] = dirs[2];
        extra[5] = dirs[3];
        pr[p].ready = 1'b1;
        pr[p].read_ok = 1'b1;
      end else if (port_en[p] && $urandom_range(0, 3) != 0) begin
        pr[p].ready = 1'b1;
        pr[p].read_ok = 1'b1;
      end
      pr[p].buttons = ~extra;
    end
    return frame_t'({2'b00, pr[1], pr[0]});
  endfunction

  task automatic push_frame(input pad_read_t a0, input pad_read_t a1);
    frames_to_send.push_back(frame_t'({2'b00, a1, a0}));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_LAYOUT: layout_sel = val[0];
      REG_PORT_ENABLE: port_en = val[1:0];
      REG_DELAY: first_repeat_delay = val;
      REG_PERIOD: repeat_every = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic drain();
    while (frames_to_send.size() != 0 || expected_reports.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic run_phase(input logic lay, input logic [1:0] en, input logic [7:0] dly,
                           input logic [7:0] per, input int idle_pct, input int stall,
                           input int count, input int hold_max, input int noise,
                           input bit squeeze);
    int         made;
    int         run_len;
    int         k;
    bit         first_run;
    logic [3:0] dirs;
    drain();
    send_idle_pct = idle_pct;
    stall_pct = stall;
    write_reg(REG_LAYOUT, {7'b0, lay});
    write_reg(REG_PORT_ENABLE, {6'b0, en});
    write_reg(REG_DELAY, dly);
    write_reg(REG_PERIOD, per);
    if (squeeze) squeeze_req++;
    made = 0;
    first_run = 1'b1;
    // keep the previous hold going across the register change
    dirs = (carry_dirs != 4'd0) ? carry_dirs : 4'($urandom_range(1, 15));
    run_len = hold_max;
    while (made < count) begin
      for (k = 0; k < run_len && made < count; k++) begin
        if (!first_run && $urandom_range(0, 99) < noise)
          push_frame(noise_pad(), noise_pad());
        else
          frames_to_send.push_back(steady_frame(dirs));
        made++;
      end
      carry_dirs = dirs;
      first_run = 1'b0;
      dirs = ($urandom_range(0, 4) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
      run_len = $urandom_range(1, hold_max);
    end
  endtask

  // frame driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (frames_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= frames_to_send[0];
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result sink, with an occasional long hold-off
  always @(negedge clk) begin
    if (squeeze_req != squeeze_seen) begin
      squeeze_seen = squeeze_req;
      squeeze_left = SQUEEZE_CYCLES;
    end
    if (squeeze_left > 0) begin
      squeeze_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin : monitor
    frame_report_t got;
    frame_report_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = frame_report_t'(m_tdata);
        if (expected_reports.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("report %0d with no frame pending: %h",
                                         reports_seen, m_tdata);
        end else begin
          want = expected_reports.pop_front();
          if (got.held !== want.held || got.pressed !== want.pressed ||
              got.released !== want.released || got.repeated !== want.repeated ||
              got.raw_buttons !== want.raw_buttons || got.stick_x !== want.stick_x ||
              got.stick_y !== want.stick_y || got.connected !== want.connected ||
              got.fill !== want.fill) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("report %0d got  held %h pr %h rel %h rep %h raw %h x %h y %h c %b",
                       reports_seen, got.held, got.pressed, got.released, got.repeated,
                       got.raw_buttons, got.stick_x, got.stick_y, got.connected);
              $display("report %0d want held %h pr %h rel %h rep %h raw %h x %h y %h c %b",
                       reports_seen, want.held, want.pressed, want.released, want.repeated,
                       want.raw_buttons, want.stick_x, want.stick_y, want.connected);
            end
          end
        end
        reports_seen++;
      end
      if (s_tvalid && s_tready) begin
        expected_reports.push_back(pad_frame_report(frame_t'(s_tdata)));
        void'(frames_to_send.pop_front());
      end
    end
    in_taken <= s_tvalid && s_tready;
  end

  // watchdog: count cycles with work pending and no beat moving
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (frames_to_send.size() == 0 && expected_reports.size() == 0))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // nothing connected, then connected but unread
    push_frame(reading(0, 0, 16'hFFFF, 0, 8'h00, 8'h00), reading(0, 0, 16'hFFFF, 0, 8'h00, 8'h00));
    push_frame(reading(1, 0, 16'h0000, 1, 8'h00, 8'hFF), reading(0, 1, 16'h0000, 1, 8'h11, 8'h22));
    // every button down, stick extremes, then port 1 takes the stick
    push_frame(reading(1, 1, 16'h0000, 1, 8'h00, 8'hFF), reading(0, 0, 16'h0000, 1, 8'h33, 8'h44));
    push_frame(reading(1, 1, 16'h0000, 1, 8'h00, 8'hFF), reading(1, 1, 16'h0000, 1, 8'hFF, 8'h00));
    push_frame(reading(1, 1, 16'hFFFF, 0, 8'h55, 8'h66), reading(1, 1, 16'hFFFF, 0, 8'h77, 8'h88));
    push_frame(reading(1, 1, 16'h5555, 1, 8'h80, 8'h80), reading(0, 1, 16'hAAAA, 1, 8'h01, 8'h01));
    push_frame(reading(1, 1, 16'hAAAA, 0, 8'h12, 8'h34), reading(1, 1, 16'h5555, 1, 8'hC8, 8'h32));
    push_frame(reading(1, 1, 16'hFFEF, 1, 8'h4D, 8'hB4), reading(1, 0, 16'h0000, 1, 8'h03, 8'h03));
    // confirm and back, both and each alone
    push_frame(reading(1, 1, ~16'h2000, 0, 8'h00, 8'h00), reading(1, 1, ~16'h4000, 0, 8'h00, 8'h00));
    push_frame(reading(1, 1, ~16'h4000, 0, 8'h00, 8'h00), reading(0, 0, 16'hFFFF, 0, 8'h00, 8'h00));
    push_frame(reading(1, 1, ~16'h2000, 0, 8'h00, 8'h00), reading(0, 0, 16'hFFFF, 0, 8'h00, 8'h00));
    // start and select; stick clicks map to nothing
    push_frame(reading(1, 1, ~16'h0009, 1, 8'hFF, 8'hFF), reading(1, 1, ~16'h0006, 0, 8'h00, 8'h00));
    push_frame(reading(1, 1, 16'hFFFF, 1, 8'hFF, 8'hFF), reading(1, 1, 16'hFFFF, 0, 8'h00, 8'h00));
    push_frame(reading(0, 1, 16'h0000, 1, 8'h05, 8'h05), reading(1, 1, ~16'hF000, 0, 8'h09, 8'h09));

    run_phase(0, 2'd3, 8'd3, 8'd2, 0, 0, 250, 20, 10, 1'b1);
    run_phase(1, 2'd3, 8'd1, 8'd1, 59, 0, 200, 10, 10, 1'b0);
    run_phase(0, 2'd1, 8'd6, 8'd4, 0, 59, 200, 30, 10, 1'b1);
    run_phase(1, 2'd2, 8'd2, 8'd3, 37, 37, 200, 15, 10, 1'b0);
    run_phase(0, 2'd0, 8'd5, 8'd5, 0, 0, 60, 10, 10, 1'b0);
    run_phase(1, 2'd3, 8'd255, 8'd3, 0, 59, 300, 290, 5, 1'b0);
    run_phase(0, 2'd3, 8'd2, 8'd255, 37, 37, 300, 290, 5, 1'b0);
    // zero delay and zero period
    run_phase(1, 2'd3, 8'd0, 8'd0, 59, 0, 150, 12, 10, 1'b0);

    drain();
    if (mismatches == 0 && expected_reports.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
